// ===== design/kvat_pkg.sv =====
// ----------------------------------------------------------------------------
// kvat_pkg
// Shared types, constants and helpers for the key/value associative table.
// ----------------------------------------------------------------------------
package kvat_pkg;

  // table geometry
  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // request and result field widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 5;

  // capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_POS = 2'd1,
    OP_DEL_KEY = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  // per-cell control from the table logic
  typedef struct packed {
    logic in_use;
    logic load;
    logic shift;
  } cell_ctrl_t;

  // integer to position index
  function automatic logic [POS_W-1:0] to_pos(input int n);
    logic [31:0] w;
    w = n;
    return w[POS_W-1:0];
  endfunction

  // integer to entry count
  function automatic logic [CNT_W-1:0] to_cnt(input int n);
    logic [31:0] w;
    w = n;
    return w[CNT_W-1:0];
  endfunction

endpackage

// ===== design/key_value_associative_table.sv =====
// ----------------------------------------------------------------------------
// key_value_associative_table
// Associative table of key/value pairs in insertion order, built as a row of
// cells that compare in parallel and shift down on removal.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         in_valid / in_stall    op, key, value, position
//  result    out        out_valid / out_stall  status, found_value,
//                                              found_position, entry_total
//  config    in         cfg_we                 cfg_data (capacity limit)
//
// per item, all cells compare, encode and shift in parallel; the result is registered
// a new item is taken every cycle while the result register is free or drains
// reset clears the entry count and sets the capacity limit to 16, no sweep
// in_stall is high only while a result is held and out_stall is high
module key_value_associative_table (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [kvat_pkg::OP_W-1:0]              op,
  input  logic [kvat_pkg::KEY_WIDTH-1:0]         key,
  input  logic [kvat_pkg::VALUE_WIDTH-1:0]       value,
  input  logic [kvat_pkg::POS_W-1:0]             position,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [kvat_pkg::STATUS_W-1:0]          status,
  output logic [kvat_pkg::VALUE_WIDTH-1:0]       found_value,
  output logic [kvat_pkg::POS_W-1:0]             found_position,
  output logic [kvat_pkg::CNT_W-1:0]             entry_total,
  input  logic                                   cfg_we,
  input  logic [kvat_pkg::CAP_W-1:0]             cfg_data
);

  logic                                accept;
  logic [kvat_pkg::CNT_W-1:0]          entry_count;
  logic [kvat_pkg::CNT_W-1:0]          entry_count_next;
  logic [kvat_pkg::CAP_W-1:0]          cap_limit;
  logic [kvat_pkg::DEPTH-1:0]          match_vec;
  logic [kvat_pkg::DEPTH-1:0]          load_vec;
  logic [kvat_pkg::DEPTH-1:0]          shift_vec;
  logic [kvat_pkg::KEY_WIDTH-1:0]      cell_key   [kvat_pkg::DEPTH];
  logic [kvat_pkg::VALUE_WIDTH-1:0]    cell_value [kvat_pkg::DEPTH];
  kvat_pkg::cell_ctrl_t                cell_ctrl  [kvat_pkg::DEPTH];
  logic                                hit;
  logic [kvat_pkg::POS_W-1:0]          hit_pos;
  logic [kvat_pkg::VALUE_WIDTH-1:0]    hit_value;
  logic                                is_full;
  logic                                load_en;
  logic                                drop_en;
  logic [kvat_pkg::POS_W-1:0]          drop_pos;
  kvat_pkg::status_t                   status_next;
  logic [kvat_pkg::VALUE_WIDTH-1:0]    found_value_next;
  logic [kvat_pkg::POS_W-1:0]          found_position_next;

  // handshake: input waits only on a held result
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // row of cells, each fed by its upper neighbour
  for (genvar i = 0; i < kvat_pkg::DEPTH; i++) begin : g_cell
    logic [kvat_pkg::KEY_WIDTH-1:0]   up_key;
    logic [kvat_pkg::VALUE_WIDTH-1:0] up_value;

    if (i < kvat_pkg::DEPTH - 1) begin : g_mid
      assign up_key   = cell_key[i+1];
      assign up_value = cell_value[i+1];
    end else begin : g_top
      assign up_key   = '0;
      assign up_value = '0;
    end

    assign cell_ctrl[i].in_use = (entry_count > kvat_pkg::to_cnt(i));
    assign cell_ctrl[i].load   = load_vec[i];
    assign cell_ctrl[i].shift  = shift_vec[i];

    kvat_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .probe_key  (key),
      .load_value (value),
      .up_key     (up_key),
      .up_value   (up_value),
      .cell_key   (cell_key[i]),
      .cell_value (cell_value[i]),
      .match      (match_vec[i])
    );

    assign load_vec[i]  = accept && load_en && (entry_count == kvat_pkg::to_cnt(i));
    assign shift_vec[i] = accept && drop_en && (kvat_pkg::to_pos(i) >= drop_pos);
  end

  // lowest matching entry wins
  always_comb begin
    hit_pos = '0;
    for (int i = kvat_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_pos = kvat_pkg::to_pos(i);
      end
    end
  end

  assign hit       = |match_vec;
  assign hit_value = cell_value[hit_pos];
  assign is_full   = (int'(entry_count) >= int'(cap_limit)) ||
                     (int'(entry_count) >= kvat_pkg::DEPTH);

  // request decode
  always_comb begin
    status_next         = kvat_pkg::ST_OK;
    found_value_next    = '0;
    found_position_next = '0;
    entry_count_next    = entry_count;
    load_en             = 1'b0;
    drop_en             = 1'b0;
    drop_pos            = position;
    case (kvat_pkg::op_t'(op))
      kvat_pkg::OP_INSERT: begin
        if (hit) begin
          status_next         = kvat_pkg::ST_DUP;
          found_position_next = hit_pos;
        end else if (is_full) begin
          status_next = kvat_pkg::ST_FULL;
        end else begin
          load_en          = 1'b1;
          entry_count_next = entry_count + kvat_pkg::to_cnt(1);
        end
      end
      kvat_pkg::OP_DEL_POS: begin
        if ({1'b0, position} >= entry_count) begin
          status_next = kvat_pkg::ST_RANGE;
        end else begin
          drop_en          = 1'b1;
          entry_count_next = entry_count - kvat_pkg::to_cnt(1);
        end
      end
      kvat_pkg::OP_DEL_KEY: begin
        if (hit) begin
          found_position_next = hit_pos;
          drop_en             = 1'b1;
          drop_pos            = hit_pos;
          entry_count_next    = entry_count - kvat_pkg::to_cnt(1);
        end else begin
          status_next = kvat_pkg::ST_MISS;
        end
      end
      kvat_pkg::OP_LOOKUP: begin
        if (hit) begin
          found_position_next = hit_pos;
          found_value_next    = hit_value;
        end else begin
          status_next = kvat_pkg::ST_MISS;
        end
      end
      default: begin
        status_next = kvat_pkg::ST_OK;
      end
    endcase
  end

  // entry count and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cap_limit   <= kvat_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
      end
      if (cfg_we) begin
        cap_limit <= cfg_data;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      found_value    <= found_value_next;
      found_position <= found_position_next;
      entry_total    <= entry_count_next;
    end
  end

`ifndef SYNTH
  // count never exceeds the number of cells
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= kvat_pkg::DEPTH)
    else $error("entry count above depth");

  // insert and shift never in the same cycle
  a_load_shift: assert property (@(posedge clk) disable iff (rst)
    !((|load_vec) && (|shift_vec)))
    else $error("load and shift together");

  // at most one cell loads
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $countones(load_vec) <= 1)
    else $error("more than one cell loading");

  // an accepted item always leaves a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item without result");

  // count moves only with an accepted item
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(entry_count))
    else $error("entry count changed without an item");
`endif

endmodule

// ===== design/kvat_cell.sv =====
// ----------------------------------------------------------------------------
// kvat_cell
// One table entry: holds a key/value pair, compares its key against the
// probe and takes its upper neighbour's pair when entries shift down.
// ----------------------------------------------------------------------------
module kvat_cell (
  input  logic                                clk,
  input  kvat_pkg::cell_ctrl_t                ctrl,
  input  logic [kvat_pkg::KEY_WIDTH-1:0]      probe_key,
  input  logic [kvat_pkg::VALUE_WIDTH-1:0]    load_value,
  input  logic [kvat_pkg::KEY_WIDTH-1:0]      up_key,
  input  logic [kvat_pkg::VALUE_WIDTH-1:0]    up_value,
  output logic [kvat_pkg::KEY_WIDTH-1:0]      cell_key,
  output logic [kvat_pkg::VALUE_WIDTH-1:0]    cell_value,
  output logic                                match
);

  // entry storage: new pair on insert, neighbour's pair on shift
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cell_key   <= probe_key;
      cell_value <= load_value;
    end else if (ctrl.shift) begin
      cell_key   <= up_key;
      cell_value <= up_value;
    end
  end

  // key compare, only for entries in use
  assign match = ctrl.in_use && (cell_key == probe_key);

endmodule

// ===== sim/key_value_associative_table_tb.sv =====
// ----------------------------------------------------------------------------
// key_value_associative_table_tb
// Self-checking bench for the key/value table. A short table of hand-written
// requests runs first, with known results typed in where they are obvious,
// then phases of random inserts, removals and lookups biased towards held
// keys. Each result is checked against its known value or a behavioural copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_value_associative_table_tb;
  import kvat_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    op_t                    op;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       position;
  } request_t;

  typedef struct packed {
    status_t                status;
    logic [VALUE_WIDTH-1:0] found_value;
    logic [POS_W-1:0]       found_position;
    logic [CNT_W-1:0]       entry_total;
  } result_t;

  typedef struct packed {
    logic             is_cap;
    logic [CAP_W-1:0] cap;
    request_t         req;
    logic             known;
    result_t          want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        op = '0;
  logic [KEY_WIDTH-1:0]   key = '0;
  logic [VALUE_WIDTH-1:0] value = '0;
  logic [POS_W-1:0]       position = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [VALUE_WIDTH-1:0] found_value;
  logic [POS_W-1:0]       found_position;
  logic [CNT_W-1:0]       entry_total;
  logic                   cfg_we = 1'b0;
  logic [CAP_W-1:0]       cfg_data = '0;

  // behavioural copy of the table
  logic [KEY_WIDTH-1:0]   held_keys [DEPTH];
  logic [VALUE_WIDTH-1:0] held_vals [DEPTH];
  int                     held_count = 0;
  int                     cap_setting = 16;

  result_t   pending_results[$];
  stim_row_t stim_rows[$];
  logic [KEY_WIDTH-1:0] key_pool [16];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  key_value_associative_table u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .key            (key),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_value    (found_value),
    .found_position (found_position),
    .entry_total    (entry_total),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // remove one held entry, later entries move down
  function automatic void drop_held(input int at);
    int i;
    for (i = at; i + 1 < held_count; i++) begin
      held_keys[i] = held_keys[i + 1];
      held_vals[i] = held_vals[i + 1];
    end
    held_count--;
  endfunction

  // apply one request to the table copy and return its result
  function automatic result_t apply_request(input request_t r);
    result_t res;
    int      hit;
    int      lim;
    int      i;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    for (i = 0; i < held_count; i++)
      if (hit < 0 && held_keys[i] == r.key) hit = i;
    lim = (cap_setting < DEPTH) ? cap_setting : DEPTH;
    case (r.op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_DUP;
          res.found_position = hit[POS_W-1:0];
        end else if (held_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          held_keys[held_count] = r.key;
          held_vals[held_count] = r.value;
          held_count++;
        end
      end
      OP_DEL_POS: begin
        if (int'(r.position) >= held_count) res.status = ST_RANGE;
        else drop_held(int'(r.position));
      end
      OP_DEL_KEY: begin
        if (hit >= 0) begin
          res.found_position = hit[POS_W-1:0];
          drop_held(hit);
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        if (hit >= 0) begin
          res.found_position = hit[POS_W-1:0];
          res.found_value = held_vals[hit];
        end else begin
          res.status = ST_MISS;
        end
      end
    endcase
    res.entry_total = held_count[CNT_W-1:0];
    return res;
  endfunction

  // offer one item, wait for acceptance, record what it should return
  task automatic offer(input request_t req, input logic known, input result_t want);
    result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= req.op;
    key      <= req.key;
    value    <= req.value;
    position <= req.position;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_request(req);
    pending_results.push_back(known ? want : got);
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = int'(cap);
  endtask

  task automatic add_item(input op_t o, input logic [KEY_WIDTH-1:0] k,
                          input logic [VALUE_WIDTH-1:0] v, input logic [POS_W-1:0] p);
    stim_row_t row;
    row = '0;
    row.req = '{op: o, key: k, value: v, position: p};
    stim_rows.push_back(row);
  endtask

  task automatic add_checked(input op_t o, input logic [KEY_WIDTH-1:0] k,
                             input logic [VALUE_WIDTH-1:0] v, input logic [POS_W-1:0] p,
                             input status_t st, input logic [VALUE_WIDTH-1:0] fv,
                             input logic [POS_W-1:0] fp, input logic [CNT_W-1:0] tot);
    stim_row_t row;
    row = '0;
    row.req = '{op: o, key: k, value: v, position: p};
    row.known = 1'b1;
    row.want = '{status: st, found_value: fv, found_position: fp, entry_total: tot};
    stim_rows.push_back(row);
  endtask

  task automatic add_cap(input logic [CAP_W-1:0] cap);
    stim_row_t row;
    row = '0;
    row.is_cap = 1'b1;
    row.cap = cap;
    stim_rows.push_back(row);
  endtask

  // one phase of random traffic at a given capacity and idling mix
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                           input int stall_pct, input int n_items, input int ins_pct,
                           input logic long_hold);
    int       n;
    int       r;
    int       sel;
    request_t req;
    wait_idle();
    write_capacity(cap);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
    for (n = 0; n < n_items; n++) begin
      // sender pauses until the table has answered everything
      if (n == n_items / 2) wait_idle();
      if (long_hold && n == 10) hold_req <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < ins_pct) req.op = OP_INSERT;
      else begin
        case (((r - ins_pct) * 3) / (100 - ins_pct))
          0:       req.op = OP_DEL_POS;
          1:       req.op = OP_DEL_KEY;
          default: req.op = OP_LOOKUP;
        endcase
      end
      // keys mostly held or from a small pool so that hits are common
      sel = $urandom_range(0, 99);
      if (sel < 45 && held_count > 0) req.key = held_keys[$urandom_range(0, held_count - 1)];
      else if (sel < 85) req.key = key_pool[$urandom_range(0, 15)];
      else req.key = $urandom();
      req.value = $urandom();
      if ($urandom_range(0, 99) < 70 && held_count > 0)
        req.position = POS_W'($urandom_range(0, held_count - 1));
      else
        req.position = POS_W'($urandom_range(0, DEPTH - 1));
      offer(req, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin : drive_requests
    int i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < 16; i++) key_pool[i] = $urandom();

    // empty table, edge values, duplicates and range errors
    add_checked(OP_LOOKUP,  32'h0,        32'h0,        4'd0,  ST_MISS,  32'h0,        4'd0, 5'd0);
    add_checked(OP_DEL_POS, 32'h0,        32'h0,        4'd0,  ST_RANGE, 32'h0,        4'd0, 5'd0);
    add_checked(OP_DEL_KEY, 32'hFFFFFFFF, 32'h0,        4'd0,  ST_MISS,  32'h0,        4'd0, 5'd0);
    add_checked(OP_INSERT,  32'h0,        32'h0,        4'd0,  ST_OK,    32'h0,        4'd0, 5'd1);
    add_checked(OP_INSERT,  32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0,  ST_OK,    32'h0,        4'd0, 5'd2);
    add_checked(OP_INSERT,  32'h0,        32'h1234,     4'd0,  ST_DUP,   32'h0,        4'd0, 5'd2);
    add_checked(OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        4'd0,  ST_OK,    32'hFFFFFFFF, 4'd1, 5'd2);
    add_checked(OP_DEL_POS, 32'h0,        32'h0,        4'd15, ST_RANGE, 32'h0,        4'd0, 5'd2);
    // removal from the middle shifts later entries down
    add_item(OP_INSERT,  32'hA5A5A5A5, 32'h5A5A5A5A, 4'd0);
    add_item(OP_INSERT,  32'h5A5A5A5A, 32'hA5A5A5A5, 4'd15);
    add_item(OP_DEL_KEY, 32'hFFFFFFFF, 32'h0,        4'd0);
    add_item(OP_LOOKUP,  32'h5A5A5A5A, 32'h0,        4'd0);
    add_item(OP_DEL_POS, 32'h0,        32'h0,        4'd0);
    // table at its limit: full, and duplicate taking priority over full
    add_cap(5'd2);
    add_checked(OP_INSERT,  32'h12345678, 32'h1,     4'd0,  ST_FULL,  32'h0,        4'd0, 5'd2);
    add_item(OP_INSERT,  32'hA5A5A5A5, 32'h0,        4'd0);
    // zero capacity and capacity below the count
    add_cap(5'd0);
    add_checked(OP_INSERT,  32'h00000001, 32'h1,     4'd0,  ST_FULL,  32'h0,        4'd0, 5'd2);
    add_checked(OP_DEL_KEY, 32'h12345678, 32'h0,     4'd0,  ST_MISS,  32'h0,        4'd0, 5'd2);
    add_item(OP_DEL_POS, 32'h0,        32'h0,        4'd1);
    add_item(OP_DEL_POS, 32'h0,        32'h0,        4'd0);
    add_checked(OP_INSERT,  32'h00000007, 32'h7,     4'd0,  ST_FULL,  32'h0,        4'd0, 5'd0);
    // capacity above the table depth
    add_cap(5'd31);
    add_item(OP_INSERT,  32'h80000000, 32'h00000001, 4'd0);
    add_item(OP_LOOKUP,  32'h80000000, 32'h0,        4'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cap) begin
        wait_idle();
        write_capacity(stim_rows[i].cap);
      end else begin
        offer(stim_rows[i].req, stim_rows[i].known, stim_rows[i].want);
      end
    end

    run_phase(5'd16, 0,  0,  300, 60, 1'b0);
    run_phase(5'd1,  76, 0,  250, 40, 1'b0);
    run_phase(5'd31, 0,  76, 300, 60, 1'b0);
    run_phase(5'd0,  34, 34, 150, 40, 1'b0);
    run_phase(5'd9,  34, 34, 250, 50, 1'b0);
    run_phase(CAP_W'($urandom_range(1, 16)), 0, 0, 250, 45, 1'b0);
    run_phase(5'd16, 0,  0,  200, 55, 1'b1);

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // receiver stalls, with one long hold-off so the table backs up
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item waiting for it");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (found_value !== want.found_value) begin
          $error("found_value: expected %h, got %h", want.found_value, found_value);
          error_count++;
        end
        if (found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position,
                 found_position);
          error_count++;
        end
        if (entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d, got %0d", want.entry_total, entry_total);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
